@@ design/d2f_pkg.sv @@
`timescale 1ns / 1ps
package d2f_pkg;

  localparam int unsigned TermCap = 30;
  localparam logic [30:0] FieldMax = 31'h7FFF_FFFF;

  // Tolerances as binary64 bit patterns.
  localparam logic [63:0] MinRemBits = 64'h3DDB_7CDF_D9D7_BDBB; // 1.0e-10
  localparam logic [63:0] MaxDevBits = 64'h3BC7_9CA1_0C92_4223; // 1.0e-20

  // Operation codes of the shared binary64 unit.
  localparam logic [1:0] OpSub = 2'd0;
  localparam logic [1:0] OpDiv = 2'd1;
  localparam logic [1:0] OpCvt = 2'd2;
  localparam logic [1:0] OpTrn = 2'd3;

  // One decoded job handed from the front end to the back end.
  typedef struct packed {
    logic        not_finite;
    logic        neg;
    logic [4:0]  limit;
    logic [63:0] mag;
  } d2f_job_t;

  typedef struct packed {
    logic [31:0] numerator;
    logic [30:0] denominator;
    logic        not_finite;
  } d2f_res_t;

  // Magnitude compare of two non-negative binary64 patterns.
  function automatic logic f64_lt(input logic [63:0] a, input logic [63:0] b);
    return a[62:0] < b[62:0];
  endfunction

endpackage

@@ design/d2f_front.sv @@
`timescale 1ns / 1ps
module d2f_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,
  input  logic [4:0]           limit_cfg,
  output logic                 job_valid,
  input  logic                 job_ready,
  output d2f_pkg::d2f_job_t    job
);
  import d2f_pkg::*;

  // Two-entry queue between the front end and the back end.
  d2f_job_t  q_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  d2f_job_t  dec;
  logic      push, pop;

  always_comb begin
    dec.not_finite = (in_tdata[62:52] == 11'h7FF);
    dec.neg        = in_tdata[63] && (in_tdata[62:0] != 63'd0);
    dec.limit      = (limit_cfg > 5'(TermCap)) ? 5'(TermCap) : limit_cfg;
    dec.mag        = {1'b0, in_tdata[62:0]};
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/d2f_fpu.sv @@
`timescale 1ns / 1ps
// Multi-cycle binary64 unit for non-negative finite operands: subtract,
// divide (restoring, one quotient bit per cycle), integer to double, and
// truncate of a value below 2^31. Results are rounded to nearest even.
module d2f_fpu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  op,      // 0 sub, 1 div, 2 int to double, 3 truncate
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] y
);
  import d2f_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIV = 4'b0010, S_NORM = 4'b0100, S_OUT = 4'b1000
  } fstate_t;

  fstate_t     st_r;
  logic [1:0]  op_r;
  logic [5:0]  cnt_r;
  logic [56:0] rem_r;       // divider remainder
  logic [52:0] dvs_r;
  logic [106:0] mant_r;     // working mantissa, bit 106 weighted by exp_r
  logic signed [12:0] exp_r; // exponent field that belongs to mant_r bit 106
  logic [63:0] y_r;

  // Unpack: value = m * 2^(e-1075), m with hidden bit.
  function automatic logic [52:0] man(input logic [63:0] x);
    return {(x[62:52] != 0), x[51:0]};
  endfunction
  function automatic logic signed [12:0] ex(input logic [63:0] x);
    return (x[62:52] == 0) ? 13'sd1 : $signed({2'b0, x[62:52]});
  endfunction

  // Subtract a-b with a >= b: align both at bit 106 scale.
  logic [106:0] sub_mant;
  logic signed [12:0] sub_exp;
  logic [11:0] sh;
  logic [106:0] bb, aa;
  always_comb begin
    sh = 12'(ex(a) - ex(b));
    aa = {man(a), 54'd0};
    bb = (sh > 12'd106) ? 107'd1 : ({man(b), 54'd0} >> sh);
    if ((sh <= 12'd106) && (({man(b), 54'd0} & ~({107{1'b1}} << sh)) != 0)) begin
      bb = bb | 107'd1;
    end
    sub_mant = aa - bb;
    sub_exp  = ex(a); // bit 106 carries the hidden bit of a
  end

  // The divider keeps its quotient in the low 58 bits; the remainder adds a
  // sticky bit below it.
  logic [106:0] pm;
  assign pm = (op_r == OpDiv) ? {mant_r[57:0], (rem_r != 0), 48'd0} : mant_r;

  // Leading-one search for normalization.
  logic [6:0] lz;
  always_comb begin
    lz = 7'd0;
    for (int i = 0; i < 107; i++) begin
      if (pm[i]) begin
        lz = 7'(106 - i);
      end
    end
  end

  // Round and pack from pm normalized to bit 106, exponent exp_r.
  logic [63:0] packed_y;
  logic [106:0] nm;
  logic signed [12:0] e;
  logic [53:0] rm;
  logic [11:0] dsh;
  logic g, st;
  always_comb begin
    nm = pm << lz;
    e  = exp_r - $signed({6'd0, lz});
    packed_y = 64'd0;
    dsh = 12'd0;
    if (e < 13'sd1) begin
      dsh = 12'(13'sd1 - e);
      if (dsh > 12'd107) begin
        nm = (nm != 0) ? 107'd1 : 107'd0;
      end else begin
        nm = (nm >> dsh) | 107'((nm & ~({107{1'b1}} << dsh)) != 0);
      end
      e = 13'sd0;
    end
    g  = nm[53];
    st = |nm[52:0];
    rm = {1'b0, nm[106:54]} + 54'(g && (st || nm[54]));
    if (pm == 0) begin
      packed_y = 64'd0;
    end else if (rm[53]) begin
      packed_y = {1'b0, 11'(e + 13'sd1), 52'd0};
    end else if (e == 0) begin
      packed_y = {1'b0, 10'd0, rm[52], rm[51:0]};
    end else begin
      packed_y = {1'b0, e[10:0], rm[51:0]};
    end
  end

  logic [52:0] ma;
  logic [11:0] tsh;
  always_comb begin
    ma  = man(a);
    tsh = 12'(13'sd1075 - ex(a));
  end

  assign done = (st_r == S_OUT);
  assign y    = y_r;

  logic [56:0] trial;
  assign trial = rem_r - {4'd0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            op_r <= op;
            unique case (op)
              OpSub: begin
                mant_r <= sub_mant;
                exp_r  <= sub_exp;
                st_r   <= S_NORM;
              end
              OpDiv: begin
                rem_r  <= {4'd0, man(a)};
                dvs_r  <= man(b);
                mant_r <= 107'd0;
                exp_r  <= ex(a) - ex(b) + 13'sd1023;
                cnt_r  <= 6'd58;
                st_r   <= S_DIV;
              end
              OpCvt: begin
                mant_r <= {a[31:0], 75'd0};
                exp_r  <= 13'sd1023 + 13'sd31;
                st_r   <= S_NORM;
              end
              OpTrn: begin
                if (a[62:52] < 11'd1023) begin
                  y_r <= 64'd0;
                end else begin
                  y_r <= 64'(ma >> tsh);
                end
                st_r <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          if (!trial[56]) begin
            rem_r <= {trial[55:0], 1'b0};
          end else begin
            rem_r <= {rem_r[55:0], 1'b0};
          end
          mant_r <= {mant_r[105:0], !trial[56]};
          cnt_r  <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            st_r <= S_NORM;
          end
        end
        S_NORM: begin
          st_r <= S_OUT;
          y_r  <= packed_y;
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/d2f_back.sv @@
`timescale 1ns / 1ps
module d2f_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  d2f_pkg::d2f_job_t    job,
  output logic                 res_valid,
  input  logic                 res_ready,
  output d2f_pkg::d2f_res_t    res
);
  import d2f_pkg::*;

  typedef enum logic [11:0] {
    B_IDLE  = 12'b000000000001, B_TRN   = 12'b000000000010,
    B_CVTA  = 12'b000000000100, B_SUBF  = 12'b000000001000,
    B_CONV  = 12'b000000010000, B_CVTN  = 12'b000000100000,
    B_CVTD  = 12'b000001000000, B_QDIV  = 12'b000010000000,
    B_DEV   = 12'b000100000000, B_RECIP = 12'b001000000000,
    B_GCD   = 12'b010000000000, B_DIVQ  = 12'b100000000000
  } bstate_t;

  bstate_t     st_r;
  d2f_job_t    job_r;
  logic [63:0] f_r, t_r, u_r;
  logic [30:0] a_r;
  logic [30:0] n1_r, d1_r, n2_r, d2_r, num_r, den_r;
  logic [62:0] cn_r, cd_r;
  logic [4:0]  i_r;
  logic        busy_r;
  logic        out_v_r;
  d2f_res_t    out_r;
  logic [30:0] gx_r, gy_r;
  logic [5:0]  gstep_r;
  logic [62:0] grem_r;
  logic [30:0] qn_r, qd_r, rn_r, rd_r;

  logic        fstart;
  logic [1:0]  fop;
  logic [63:0] fa, fb, fy;
  logic        fdone;

  d2f_fpu u_fpu (
    .clk(clk), .rst_n(rst_n), .start(fstart), .op(fop), .a(fa), .b(fb),
    .done(fdone), .y(fy)
  );

  assign job_ready = (st_r == B_IDLE) && !out_v_r;
  assign res_valid = out_v_r;
  assign res       = out_r;

  // The FPU is started once per step; busy_r marks a started operation.
  always_comb begin
    fstart = 1'b0;
    fop    = OpSub;
    fa     = 64'd0;
    fb     = 64'd0;
    unique case (st_r)
      B_TRN:   begin fop = OpTrn; fa = f_r; end
      B_CVTA:  begin fop = OpCvt; fa = {33'd0, a_r}; end
      B_SUBF:  begin fop = OpSub; fa = f_r; fb = t_r; end
      B_CVTN:  begin fop = OpCvt; fa = {33'd0, num_r}; end
      B_CVTD:  begin fop = OpCvt; fa = {33'd0, den_r}; end
      B_QDIV:  begin fop = OpDiv; fa = t_r; fb = u_r; end
      B_DEV:   begin fop = OpSub;
        fa = f64_lt(job_r.mag, t_r) ? t_r : job_r.mag;
        fb = f64_lt(job_r.mag, t_r) ? job_r.mag : t_r; end
      B_RECIP: begin fop = OpDiv; fa = 64'h3FF0_0000_0000_0000; fb = f_r; end
      default: ;
    endcase
    if (st_r != B_IDLE && st_r != B_CONV && st_r != B_GCD && st_r != B_DIVQ) begin
      fstart = !busy_r;
    end
  end

  logic [62:0] mn, md;
  assign mn = 63'(n1_r) * 63'(a_r);
  assign md = 63'(d1_r) * 63'(a_r);

  // Remainder step of Euclid and the two quotient lanes of the final reduction.
  logic        grem_ge, qn_ge, qd_ge;
  logic [31:0] qn_sh, qd_sh;
  assign grem_ge = grem_r[62:31] >= {1'b0, gy_r};
  assign qn_sh   = {rn_r, qn_r[30]};
  assign qd_sh   = {rd_r, qd_r[30]};
  assign qn_ge   = qn_sh >= {1'b0, gx_r};
  assign qd_ge   = qd_sh >= {1'b0, gx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && res_ready) begin
        out_v_r <= 1'b0;
      end
      if (fstart) begin
        busy_r <= 1'b1;
      end else if (fdone) begin
        busy_r <= 1'b0;
      end
      unique case (st_r)
        B_IDLE: begin
          if (job_valid && job_ready) begin
            job_r <= job;
            f_r   <= job.mag;
            n1_r  <= 31'd1; d1_r <= 31'd0; n2_r <= 31'd0; d2_r <= 31'd1;
            num_r <= 31'd1; den_r <= 31'd1;
            i_r   <= 5'd0;
            if (job.not_finite) begin
              out_r   <= '{numerator: 32'd0, denominator: 31'd1, not_finite: 1'b1};
              out_v_r <= 1'b1;
            end else if (job.limit == 5'd0) begin
              st_r <= B_GCD;
              gx_r <= 31'd1; gy_r <= 31'd1;
              gstep_r <= 6'd0;
            end else begin
              st_r <= B_TRN;
            end
          end
        end
        B_TRN: begin
          if (!fstart && f_r[62:52] >= 11'd1054) begin
            st_r <= B_GCD; gx_r <= num_r; gy_r <= den_r; gstep_r <= 6'd0;
          end else if (fdone) begin
            a_r <= fy[30:0];
            st_r <= B_CVTA;
          end
        end
        B_CVTA: begin
          if (fdone) begin t_r <= fy; st_r <= B_SUBF; end
        end
        B_SUBF: begin
          if (fdone) begin
            f_r  <= fy;
            cn_r <= mn + 63'(n2_r);
            cd_r <= md + 63'(d2_r);
            st_r <= B_CONV;
          end
        end
        B_CONV: begin
          if (cn_r > 63'(FieldMax) || cd_r > 63'(FieldMax)) begin
            st_r <= B_GCD; gx_r <= num_r; gy_r <= den_r; gstep_r <= 6'd0;
          end else begin
            num_r <= cn_r[30:0]; den_r <= cd_r[30:0];
            n2_r <= n1_r; d2_r <= d1_r;
            n1_r <= cn_r[30:0]; d1_r <= cd_r[30:0];
            st_r <= B_CVTN;
          end
        end
        B_CVTN: begin
          if (fdone) begin t_r <= fy; st_r <= B_CVTD; end
        end
        B_CVTD: begin
          if (fdone) begin u_r <= fy; st_r <= B_QDIV; end
        end
        B_QDIV: begin
          if (fdone) begin t_r <= fy; st_r <= B_DEV; end
        end
        B_DEV: begin
          if (fdone) begin
            if (f64_lt(f_r, MinRemBits) || f64_lt(fy, MaxDevBits) ||
                (i_r + 5'd1 == job_r.limit)) begin
              st_r <= B_GCD; gx_r <= num_r; gy_r <= den_r; gstep_r <= 6'd0;
            end else begin
              st_r <= B_RECIP;
            end
          end
        end
        B_RECIP: begin
          if (fdone) begin
            f_r <= fy;
            i_r <= i_r + 5'd1;
            st_r <= B_TRN;
          end
        end
        B_GCD: begin
          // Euclid by shift-subtract remainder, one quotient bit per cycle.
          if (gy_r == 31'd0) begin
            qn_r    <= num_r;
            qd_r    <= den_r;
            rn_r    <= 31'd0;
            rd_r    <= 31'd0;
            gstep_r <= 6'd31;
            st_r    <= B_DIVQ;
          end else if (gstep_r == 6'd0) begin
            grem_r  <= {32'd0, gx_r};
            gstep_r <= 6'd32;
          end else begin
            if (grem_ge) begin
              grem_r <= {grem_r[62:31] - {1'b0, gy_r}, grem_r[30:0]} << 1;
            end else begin
              grem_r <= grem_r << 1;
            end
            gstep_r <= gstep_r - 6'd1;
            if (gstep_r == 6'd1) begin
              gx_r <= gy_r;
              gy_r <= grem_ge ? 31'(grem_r[62:31] - {1'b0, gy_r}) : grem_r[61:31];
            end
          end
        end
        B_DIVQ: begin
          // Numerator and denominator are divided by the gcd side by side.
          if (gstep_r == 6'd0) begin
            if (!out_v_r) begin
              out_r.numerator   <= job_r.neg ? (32'd0 - {1'b0, qn_r}) : {1'b0, qn_r};
              out_r.denominator <= qd_r;
              out_r.not_finite  <= 1'b0;
              out_v_r <= 1'b1;
              st_r    <= B_IDLE;
            end
          end else begin
            qn_r    <= {qn_r[29:0], qn_ge};
            qd_r    <= {qd_r[29:0], qd_ge};
            rn_r    <= qn_ge ? 31'(qn_sh - {1'b0, gx_r}) : qn_sh[30:0];
            rd_r    <= qd_ge ? 31'(qd_sh - {1'b0, gx_r}) : qd_sh[30:0];
            gstep_r <= gstep_r - 6'd1;
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/double_to_fraction.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Word
// in_       slave      tdata[63:0] value_bits
// out_      master     tdata[31:0] numerator, [62:32] denominator, [63] not_finite
// cfg_      write      wdata[4:0] term_limit
//
// Each continued fraction term is worked out on the shared binary64 unit,
// whose divider yields one quotient bit a cycle; the last term needs no
// reciprocal. Euclid steps then find the gcd, and the numerator and the
// denominator are divided by it. NaN and infinity skip the expansion. Reset
// is synchronous and active low. A two-word queue lets the input side keep
// accepting while the back end or the output stalls.
module double_to_fraction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // numerator, denominator, not_finite
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data // term_limit
);
  import d2f_pkg::*;

  logic [4:0] limit_r;
  logic       job_valid, job_ready;
  d2f_job_t   job;
  d2f_res_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 5'(TermCap);
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  d2f_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .limit_cfg(limit_r), .job_valid(job_valid),
    .job_ready(job_ready), .job(job)
  );

  d2f_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {res.not_finite, res.denominator, res.numerator};

  // A finished result never has a zero denominator.
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[62:32] != 31'd0) else $error("zero denominator");
  // A flagged word always has a zero numerator; the back end sends it as 0/1.
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63] |-> out_tdata[31:0] == 32'd0)
    else $error("non-finite result not zero");
  // The stored limit follows a write.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> limit_r == $past(cfg_wr_data)) else $error("limit not written");

endmodule

@@ bench/tb_double_to_fraction.sv @@
`timescale 1ns / 1ps
// This bench drives binary64 words into double_to_fraction and checks every fraction
// that comes back.
// Expected fractions come from an in-bench continued fraction expansion that
// uses the simulator's own double arithmetic.
module tb_double_to_fraction;
  import d2f_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // value_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // numerator, denominator, not_finite
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data; // term_limit

  // This is the bench's copy of the term limit register.
  logic [4:0]  term_limit_q;
  d2f_res_t    fraction_q[$];
  bit          calm;
  bit          failed;

  double_to_fraction u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // The receiver stalls about a third of the time, except during a calm stretch.
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // This function computes the best rational approximation for one word.
  function automatic d2f_res_t rational_of(input logic [63:0] bits);
    real             v, f, dev;
    bit              neg;
    longint unsigned n1, d1, n2, d2, num, den, a, cn, cd, x, y, r;
    int              lim, i;
    logic [31:0]     snum;
    d2f_res_t        res;
    n1 = 1; d1 = 0; n2 = 0; d2 = 1; num = 1; den = 1; neg = 0;
    if (bits[62:52] == 11'h7FF) begin
      res.numerator = '0;
      res.denominator = 31'd1;
      res.not_finite = 1'b1;
      return res;
    end
    v = $bitstoreal(bits);
    if (v < 0.0) begin
      v = -v;
      neg = 1;
    end
    f = v;
    lim = (term_limit_q > TermCap) ? TermCap : term_limit_q;
    for (i = 0; i < lim; i++) begin
      // A term that cannot fit in 31 bits ends the expansion, as overflow does.
      if (f >= 2147483648.0) break;
      a = $rtoi(f);
      f = f - real'(a);
      cn = n1 * a + n2;
      cd = d1 * a + d2;
      if (cn > 64'(FieldMax) || cd > 64'(FieldMax)) break;
      num = cn; den = cd;
      n2 = n1; d2 = d1;
      n1 = cn; d1 = cd;
      dev = v - real'(num) / real'(den);
      if (dev < 0.0) dev = -dev;
      if (f < 1.0e-10 || dev < 1.0e-20) break;
      f = 1.0 / f;
    end
    x = num;
    y = den;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    if (x != 0) begin
      num = num / x;
      den = den / x;
    end
    snum = num[31:0];
    if (neg) snum = 32'd0 - snum;
    res.numerator = snum;
    res.denominator = den[30:0];
    res.not_finite = 1'b0;
    return res;
  endfunction

  // Each result word is compared with the oldest pending fraction.
  always @(posedge clk) begin
    d2f_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (fraction_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $realtime, out_tdata);
        failed = 1;
      end else begin
        exp_r = fraction_q.pop_front();
        if (out_tdata[31:0] !== exp_r.numerator) begin
          $display("%0t: numerator expected %h actual %h", $realtime,
                   exp_r.numerator, out_tdata[31:0]);
          failed = 1;
        end
        if (out_tdata[62:32] !== exp_r.denominator) begin
          $display("%0t: denominator expected %h actual %h", $realtime,
                   exp_r.denominator, out_tdata[62:32]);
          failed = 1;
        end
        if (out_tdata[63] !== exp_r.not_finite) begin
          $display("%0t: not_finite expected %b actual %b", $realtime,
                   exp_r.not_finite, out_tdata[63]);
          failed = 1;
        end
      end
    end
  end

  // This task sends one word, with a random gap in front of it unless the phase is calm.
  task automatic send_value(input logic [63:0] bits);
    if (!calm && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    do @(posedge clk); while (!in_tready);
    fraction_q.push_back(rational_of(bits));
  endtask

  // This task waits for every pending fraction, then lets the back end settle.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (fraction_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_term_limit(input logic [4:0] lim);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    term_limit_q = lim;
  endtask

  // Most values lie in a moderate range, so that the expansion runs several terms.
  function automatic logic [63:0] moderate_value();
    real q;
    case ($urandom_range(2))
      0: begin
        q = real'($urandom_range(1, 100000)) / real'($urandom_range(1, 100000));
        return $realtobits($urandom_range(1) ? -q : q);
      end
      1: return {1'($urandom), 11'($urandom_range(1000, 1053)), $urandom, 20'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed;
    logic [63:0] vals[$];
    vals = '{64'h0, 64'h8000_0000_0000_0000, $realtobits(1.0), $realtobits(-1.0),
             $realtobits(0.5), $realtobits(3.141592653589793), $realtobits(1.0 / 3.0),
             $realtobits(-1.4142135623730951), 64'h7FF8_0000_0000_0001,
             64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
             $realtobits(2147483648.0), $realtobits(2147483647.5),
             $realtobits(2147483647.0), $realtobits(-1.0e300), 64'h7FEF_FFFF_FFFF_FFFF,
             64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001, $realtobits(1.0e-11),
             $realtobits(4.0e-10), $realtobits(1.0 + 1.0e-9)};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Limits of zero, one and above thirty, each with three values.
  task automatic test_limit_extremes;
    logic [4:0] lims[$];
    lims = '{5'd0, 5'd31, 5'd1};
    foreach (lims[i]) begin
      set_term_limit(lims[i]);
      send_value($realtobits(-2.75));
      send_value($realtobits(3.141592653589793));
      send_value(64'h8000_0000_0000_0000);
    end
  endtask

  task automatic test_random(input int count, input logic [4:0] lim, input bit quiet);
    set_term_limit(lim);
    calm = quiet;
    repeat (count) send_value(moderate_value());
    calm = 0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    out_tready  = 1'b0;
    calm        = 0;
    failed      = 0;
    term_limit_q = 5'd30;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit_extremes();
    test_random(500, 5'd4, 0);
    test_random(400, 5'd8, 1);
    test_random(500, 5'($urandom_range(2, 12)), 0);
    test_random(300, 5'd2, 0);
    test_random(150, 5'd30, 0);
    drain();
    if (!failed)
      $display("double_to_fraction test passed");
    else
      $display("double_to_fraction test failed");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("double_to_fraction test failed");
    $finish;
  end

endmodule
